>>> rtl/csrd_pkg.sv
// Shared constants and types for the cadence sensor rpm/direction block.
package csrd_pkg;

    localparam int COUNT_W   = 16;                 // tick counter width
    localparam int SCALE_W   = 20;                 // rpm_scale register width
    localparam int TIMEOUT_W = 16;                 // timeout_ticks register width
    localparam int QUO_W     = 8;                  // rpm width, saturating quotient
    localparam int STEP_W    = $clog2(QUO_W);
    localparam int HIGH_W    = SCALE_W - QUO_W;    // dividend bits above the quotient
    localparam int REM_W     = ((HIGH_W > COUNT_W) ? HIGH_W : COUNT_W) + 1;
    localparam int CMP_W     = (COUNT_W > TIMEOUT_W) ? COUNT_W : TIMEOUT_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [COUNT_W-1:0]   COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = SCALE_W'(25000);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
    localparam logic [QUO_W-1:0]     RPM_SAT       = {QUO_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RPM_SCALE = 1'b0,
        REG_TIMEOUT   = 1'b1
    } cfg_reg_t;

    // divider result bundle
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

>>> rtl/csrd_div.sv
// Serial saturating divider: one shared subtractor, one quotient bit per cycle.
module csrd_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [csrd_pkg::SCALE_W-1:0] dividend,
    input  logic [csrd_pkg::COUNT_W-1:0] divisor,
    output csrd_pkg::div_res_t      res
);
    import csrd_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_SHIFT} dstate_t;

    dstate_t             state_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    low_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [COUNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;

    logic [REM_W-1:0]    trial;
    logic [REM_W:0]      diff;
    logic                fits;

    // shared subtractor: saturation check first, then restoring steps
    always_comb
    begin
        if (state_reg == D_CHECK)
        begin
            trial = rem_reg;
        end
        else
        begin
            trial = {rem_reg[REM_W-2:0], low_reg[QUO_W-1]};
        end
        diff = {1'b0, trial} - {1'b0, REM_W'(dvs_reg)};
        fits = ~diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= REM_W'(dividend[SCALE_W-1:QUO_W]);
                        low_reg   <= dividend[QUO_W-1:0];
                        dvs_reg   <= divisor;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    if (fits)
                    begin
                        // quotient would exceed the rpm range
                        quo_reg   <= RPM_SAT;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        state_reg <= D_SHIFT;
                    end
                end
                D_SHIFT:
                begin
                    rem_reg  <= fits ? diff[REM_W-1:0] : trial;
                    low_reg  <= {low_reg[QUO_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[QUO_W-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QUO_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

endmodule

>>> rtl/cadence_sensor_rpm_direction_core.sv
// Top level: pedal cadence period measurement to rpm with direction flags.
//
//  channel   dir  beat contents                                    handshake
//  s_axis    in   tdata[0] pedal_a, [1] pedal_b, [7:2] zero         tvalid/tready
//  m_axis    out  tdata[7:0] rpm, [8] fwd, [9] bwd, [15:10] zero    tvalid/tready
//  cfg       in   cfg_addr 0 rpm_scale, 1 timeout_ticks             cfg_we, no wait
//
// A tick without a rising edge of pedal_a passes through accept and result write.
// A rising edge passes through accept, one saturation check plus eight
// restoring steps in the shared subtractor of csrd_div, handoff and result write.
// When the check already shows a quotient above 255 the steps are skipped.
// The result sits in an output register; a stalled m_axis holds the block in the
// write state and s_axis tready stays low until the result register frees up.
// rst_n clears all counters, held rpm, direction and restores register defaults.
module cadence_sensor_rpm_direction_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] pedal_a, [1] pedal_b
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // [7:0] cadence_rpm,
                                                            // [8] pedaling_forward,
                                                            // [9] pedaling_backward
    // configuration writes
    input  logic                            cfg_we,
    input  logic [csrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [csrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import csrd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_WRITE} state_t;

    state_t               state_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [COUNT_W-1:0]   tick_count_reg;
    logic                 last_a_reg;
    logic                 backward_reg;
    logic                 b_pend_reg;
    logic [QUO_W-1:0]     held_rpm_reg;
    logic                 out_valid_reg;
    logic [15:0]          out_data_reg;

    logic                 accept;
    logic                 pedal_a;
    logic                 pedal_b;
    logic                 rise;
    logic [COUNT_W-1:0]   count_inc;
    logic                 timed_out;
    logic                 out_free;
    div_res_t             div_res;

    assign pedal_a  = s_axis_tdata[0];
    assign pedal_b  = s_axis_tdata[1];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign rise     = pedal_a && !last_a_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    // saturating tick count, incremented before the edge test
    assign count_inc = (tick_count_reg == COUNT_MAX) ? tick_count_reg
                                                     : COUNT_W'(tick_count_reg + 1'b1);
    assign timed_out = (held_rpm_reg != '0) &&
                       (CMP_W'(count_inc) > CMP_W'(timeout_reg));

    csrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && rise),
        .dividend (scale_reg),
        .divisor  (count_inc),
        .res      (div_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_RPM_SCALE: scale_reg   <= cfg_wdata;
                REG_TIMEOUT:   timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer, measurement state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            last_a_reg     <= 1'b0;
            backward_reg   <= 1'b0;
            b_pend_reg     <= 1'b0;
            held_rpm_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            // the write state loads the output register itself
            if (m_axis_tready && state_reg != S_WRITE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_a_reg <= pedal_a;
                        if (rise)
                        begin
                            // period ends: restart count, start the divider and wait for it
                            tick_count_reg <= '0;
                            b_pend_reg     <= pedal_b;
                            state_reg      <= S_DIV;
                        end
                        else
                        begin
                            tick_count_reg <= count_inc;
                            if (timed_out)
                            begin
                                held_rpm_reg <= '0;
                                backward_reg <= 1'b0;
                            end
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        held_rpm_reg <= div_res.quo;
                        backward_reg <= b_pend_reg;
                        state_reg    <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'b0,
                                          (held_rpm_reg != '0) && backward_reg,
                                          (held_rpm_reg != '0) && !backward_reg,
                                          held_rpm_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // divider only reports back while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider result outside divide state");

    // a rising edge restarts the tick count
    a_edge_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rise |=> tick_count_reg == '0)
        else $error("tick count not restarted on edge");

    // direction flags never both set, and only with nonzero rpm
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("forward and backward both set");

    a_flags_need_rpm: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[8] || m_axis_tdata[9]) |->
            m_axis_tdata[7:0] != 8'd0)
        else $error("direction flag with zero rpm");

endmodule

>>> tb/cadence_sensor_rpm_direction_core_test.sv
// Self-checking testbench for the cadence sensor rpm/direction core.
module cadence_sensor_rpm_direction_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csrd_pkg::*;

    // one sample tick on the input stream
    typedef struct packed {
        logic b;
        logic a;
    } pedal_tick_t;

    // one cadence beat on the output stream
    typedef struct packed {
        logic             bwd;
        logic             fwd;
        logic [QUO_W-1:0] rpm;
    } cadence_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_data = '0;       // [0] pedal_a, [1] pedal_b

    logic                  m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [15:0]           m_axis_tdata;      // [7:0] rpm, [8] fwd, [9] bwd

    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // pending ticks for the driver, expected cadence beats for the monitor
    pedal_tick_t tick_q[$];
    cadence_t    cadence_expected_q[$];

    // idling knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off
    logic        hold_req = 1'b0;
    int unsigned hold_left = 0;

    // predictor copy of the block state and registers
    logic [COUNT_W-1:0]   tick_cnt = '0;
    logic                 prev_a = 1'b0;
    logic                 going_bwd = 1'b0;
    logic [QUO_W-1:0]     held_rpm = '0;
    logic [SCALE_W-1:0]   scale_reg = SCALE_RESET;
    logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RESET;

    // bookkeeping
    int unsigned err_count = 0;
    int unsigned ticks_in = 0;
    int unsigned beats_checked = 0;
    int unsigned edge_ticks = 0;
    int unsigned rpm_clears = 0;
    int unsigned rpm_sats = 0;
    int unsigned count_sat_ticks = 0;

    cadence_sensor_rpm_direction_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Period measurement on one tick: count first (saturating), then either a
    // rising edge of pedal_a latches direction and divides, or the timeout
    // clears a running rpm.
    function automatic cadence_t measure_cadence(logic a, logic b);
        cadence_t           res;
        logic [SCALE_W-1:0] quo;
        if (tick_cnt != COUNT_MAX)
        begin
            tick_cnt = tick_cnt + 1'b1;
        end
        else
        begin
            count_sat_ticks++;
        end
        if (a && !prev_a)
        begin
            edge_ticks++;
            quo = scale_reg / tick_cnt;
            going_bwd = b;
            if (quo > SCALE_W'(RPM_SAT))
            begin
                held_rpm = RPM_SAT;
                rpm_sats++;
            end
            else
            begin
                held_rpm = quo[QUO_W-1:0];
            end
            tick_cnt = '0;
        end
        else if (held_rpm != '0 && CMP_W'(tick_cnt) > CMP_W'(timeout_reg))
        begin
            held_rpm = '0;
            going_bwd = 1'b0;
            rpm_clears++;
        end
        prev_a = a;
        res.rpm = held_rpm;
        res.fwd = (held_rpm != '0) && !going_bwd;
        res.bwd = (held_rpm != '0) && going_bwd;
        return res;
    endfunction

    // Driver: offers ticks from tick_q, predicts on every accepted beat.
    // tvalid only changes when nothing is pending or the beat was just taken.
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        pedal_tick_t t;
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end
        else
        begin
            if (s_valid && s_axis_tready)
            begin
                cadence_expected_q.push_back(measure_cadence(s_data[0], s_data[1]));
                ticks_in++;
            end
            if (!s_valid || s_axis_tready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    t = tick_q.pop_front();
                    s_data  <= {6'b0, t.b, t.a};
                    s_valid <= 1'b1;
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter, kicked by a one-cycle request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            hold_left <= 400;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compares each taken cadence beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : cadence_monitor
        cadence_t got;
        cadence_t want;
        if (!rst_n)
        begin
            m_ready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_ready)
            begin
                got.rpm = m_axis_tdata[7:0];
                got.fwd = m_axis_tdata[8];
                got.bwd = m_axis_tdata[9];
                beats_checked++;
                if (cadence_expected_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 20)
                    begin
                        $display("%0t: unexpected beat, got rpm %0d fwd %0b bwd %0b",
                                 $realtime, got.rpm, got.fwd, got.bwd);
                    end
                end
                else
                begin
                    want = cadence_expected_q.pop_front();
                    if (got.rpm !== want.rpm || got.fwd !== want.fwd
                        || got.bwd !== want.bwd)
                    begin
                        err_count++;
                        if (err_count <= 20)
                        begin
                            $display({"%0t: mismatch, expected rpm %0d fwd %0b bwd %0b,",
                                      " got rpm %0d fwd %0b bwd %0b"},
                                     $realtime, want.rpm, want.fwd, want.bwd,
                                     got.rpm, got.fwd, got.bwd);
                        end
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_tick(logic a, logic b);
        pedal_tick_t t;
        t.a = a;
        t.b = b;
        tick_q.push_back(t);
    endtask

    // Sender pause: everything offered, taken and answered, then let the
    // divider settle before touching registers. Checked at the falling edge,
    // after the driver's updates have landed.
    task automatic wait_idle();
        while (tick_q.size() != 0 || s_valid || cadence_expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_RPM_SCALE)
        begin
            scale_reg = val;
        end
        else
        begin
            timeout_reg = val[TIMEOUT_W-1:0];
        end
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1: begin send_idle_pct <= 52; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 52; end
            3: begin send_idle_pct <= 20; recv_stall_pct <= 20; end
            default: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
        endcase
    endtask

    // Mostly pedaling-like waveforms with random period and direction,
    // plus stops long enough to time out and some raw noise.
    task automatic add_pedal_traffic(int n_ticks);
        int   start;
        int   pick;
        int   hi;
        int   lo;
        int   len;
        logic dir;
        logic lvl;
        start = tick_q.size();
        while (tick_q.size() - start < n_ticks)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                hi  = $urandom_range(1, 20);
                lo  = $urandom_range(1, 20);
                dir = 1'($urandom_range(1));
                repeat ($urandom_range(1, 6))
                begin
                    add_tick(1'b1, dir);
                    repeat (hi - 1) add_tick(1'b1, 1'($urandom_range(1)));
                    repeat (lo) add_tick(1'b0, 1'($urandom_range(1)));
                end
            end
            else if (pick < 85)
            begin
                lvl = 1'($urandom_range(1));
                len = $urandom_range(1, 150);
                repeat (len) add_tick(lvl, 1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    add_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic random_phase(int mode, logic [CFG_DATA_W-1:0] scale,
                                logic [CFG_DATA_W-1:0] tmo, int n_ticks, bit long_hold);
        write_reg(REG_RPM_SCALE, scale);
        write_reg(REG_TIMEOUT, tmo);
        set_idling(mode);
        @(negedge clk);
        add_pedal_traffic(n_ticks);
        if (long_hold)
        begin
            // receiver holds off while the sender keeps offering ticks
            @(posedge clk);
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset registers; pedal_a high on the very first tick is an
        // edge (backward, saturated rpm), then a forward edge.
        @(negedge clk);
        add_tick(1'b1, 1'b1);
        add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b0);
        add_tick(1'b0, 1'b1);
        add_tick(1'b1, 1'b0);
        wait_idle();

        // register maxima: huge quotient saturates
        write_reg(REG_RPM_SCALE, 20'hFFFFF);
        write_reg(REG_TIMEOUT, 20'h0FFFF);
        @(negedge clk);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b1);
        wait_idle();

        // zero scale: edge gives rpm 0 with direction latched, flags low
        write_reg(REG_RPM_SCALE, '0);
        write_reg(REG_TIMEOUT, '0);
        @(negedge clk);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        wait_idle();

        // zero timeout: a nonzero rpm is dropped on the next edgeless tick
        write_reg(REG_RPM_SCALE, 20'd3);
        @(negedge clk);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);
        add_tick(1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        wait_idle();

        // short timeout: steady backward pedaling, then a stop
        write_reg(REG_RPM_SCALE, 20'd600);
        write_reg(REG_TIMEOUT, 20'd3);
        @(negedge clk);
        repeat (3)
        begin
            add_tick(1'b1, 1'b1);
            add_tick(1'b1, 1'b0);
            add_tick(1'b0, 1'b0);
            add_tick(1'b0, 1'b1);
        end
        repeat (5) add_tick(1'b0, 1'b0);
        wait_idle();

        // Random traffic, one idling mode per phase, several register settings.
        random_phase(0, 20'($urandom_range(1, 8000)), 20'($urandom_range(1, 100)), 70, 1);
        random_phase(1, 20'($urandom_range(1, 8000)), 20'($urandom_range(1, 100)), 70, 0);
        random_phase(2, 20'($urandom_range(1, 40)), 20'd1, 70, 0);
        random_phase(3, 20'hFFFFF, 20'($urandom_range(1, 100)), 70, 0);
        random_phase(0, 20'($urandom_range(1, 4000)), 20'($urandom_range(1, 60)), 70, 0);
        random_phase(1, 20'($urandom_range(1, 1048575)), 20'($urandom_range(1, 200)),
                     70, 0);
        random_phase(2, 20'($urandom_range(100, 3000)), 20'($urandom_range(1, 100)), 70, 0);
        random_phase(3, 20'($urandom_range(1, 8000)), 20'($urandom_range(1, 100)), 70, 0);

        repeat (20) @(posedge clk);
        $display("covered %0d ticks, %0d beats checked: %0d edges, %0d saturated rpm,",
                 ticks_in, beats_checked, edge_ticks, rpm_sats);
        $display("  %0d timeout clears, %0d ticks at the saturated count",
                 rpm_clears, count_sat_ticks);
        if (err_count == 0)
        begin
            $display("cadence_sensor_rpm_direction_core_test: clean");
        end
        else
        begin
            $display("cadence_sensor_rpm_direction_core_test: errors");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("watchdog expired with %0d beats outstanding", cadence_expected_q.size());
        $display("cadence_sensor_rpm_direction_core_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/csrd_pkg.sv
rtl/csrd_div.sv
rtl/cadence_sensor_rpm_direction_core.sv
tb/cadence_sensor_rpm_direction_core_test.sv
